// ----- rtl/htts_pkg.sv -----
// shared types and constants for the histogram top-three select block
`timescale 1ns / 1ps

package htts_pkg;

    localparam int SLOTS = 3;
    localparam int IDX_W = 6;
    localparam int CNT_W = 16;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INC    = 2'd1;
    localparam logic [1:0] CMD_SELECT = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLEAR = 6'b000010,
        S_INC   = 6'b000100,
        S_SCAN  = 6'b001000,
        S_LAST  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    typedef struct packed {
        logic clear;
        logic insert;
    } t_rank_ctl;

endpackage

// ----- rtl/histogram_top_three_select_top.sv -----
// top level of the histogram with top-three select
`timescale 1ns / 1ps

// Histogram of ENTRIES saturating counters with a top-three select.
// Input channel: i_valid / o_stall carry a request of i_cmd and
// i_entry_index; a request is taken when i_valid is high and o_stall low.
// Clear zeroes every counter, one counter per cycle.
// Increment reads then writes one counter and gives no result.
// Select walks the counter memory once, one entry per cycle through a
// single insertion compare unit; the ranked list then loads the result
// register. The memory's one read port sets that rate.
// Output channel: o_valid / i_stall carry the first, second and third
// index, valid and count. A result is held steady while i_stall is high;
// a new request may be taken meanwhile, and a later select waits at its
// end until the held result is taken.
// Slots with a zero count read as index 0, valid 0, count 0.
// After reset the block runs a clearing pass over the counter memory
// with o_stall high; no result is pending after reset.
module histogram_top_three_select_top #(
    parameter int ENTRIES    = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [5:0]  i_entry_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_first_index,
    output logic        o_first_valid,
    output logic [15:0] o_first_count,
    output logic [5:0]  o_second_index,
    output logic        o_second_valid,
    output logic [15:0] o_second_count,
    output logic [5:0]  o_third_index,
    output logic        o_third_valid,
    output logic [15:0] o_third_count
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = COUNT_BITS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);
    localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

    htts_pkg::t_state r_state;
    htts_pkg::t_state n_state;
    logic [AW-1:0]    r_addr;
    logic [AW-1:0]    n_addr;
    logic [CW-1:0]    r_mem [ENTRIES];
    logic [CW-1:0]    r_rd_data;
    logic             r_rd_vld;
    logic [AW-1:0]    r_rd_idx;

    logic             accept;
    logic             in_range;
    logic [AW-1:0]    in_addr;
    logic [AW-1:0]    mem_raddr;
    logic             mem_we;
    logic [CW-1:0]    mem_wdata;
    logic             out_load;
    logic             r_out_valid;

    htts_pkg::t_rank_ctl                      rank_ctl;
    logic [htts_pkg::SLOTS-1:0]               slot_valid;
    logic [htts_pkg::SLOTS-1:0][AW-1:0]       slot_index;
    logic [htts_pkg::SLOTS-1:0][CW-1:0]       slot_count;
    logic [htts_pkg::SLOTS-1:0]               r_res_valid;
    logic [htts_pkg::SLOTS-1:0][htts_pkg::IDX_W-1:0] r_res_index;
    logic [htts_pkg::SLOTS-1:0][htts_pkg::CNT_W-1:0] r_res_count;

    assign accept   = i_valid && (r_state == htts_pkg::S_IDLE);
    assign o_stall  = (r_state != htts_pkg::S_IDLE);
    assign in_addr  = AW'(i_entry_index);
    assign in_range = (32'(i_entry_index) < ENTRIES);
    assign out_load = (r_state == htts_pkg::S_DONE) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        case (r_state)
            htts_pkg::S_IDLE: begin
                if (i_valid) begin
                    case (i_cmd)
                        htts_pkg::CMD_CLEAR: begin
                            n_state = htts_pkg::S_CLEAR;
                            n_addr  = '0;
                        end
                        htts_pkg::CMD_INC: begin
                            if (in_range) begin
                                n_state = htts_pkg::S_INC;
                                n_addr  = in_addr;
                            end
                        end
                        htts_pkg::CMD_SELECT: begin
                            n_state = htts_pkg::S_SCAN;
                            n_addr  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            htts_pkg::S_CLEAR: begin
                n_addr = r_addr + AW'(1);
                if (r_addr == LAST_ADDR) begin
                    n_state = htts_pkg::S_IDLE;
                end
            end
            htts_pkg::S_INC: begin
                n_state = htts_pkg::S_IDLE;
            end
            htts_pkg::S_SCAN: begin
                n_addr = r_addr + AW'(1);
                if (r_addr == LAST_ADDR) begin
                    n_state = htts_pkg::S_LAST;
                end
            end
            htts_pkg::S_LAST: begin
                n_state = htts_pkg::S_DONE;
            end
            htts_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = htts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = htts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= htts_pkg::S_CLEAR;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_rd_vld <= (r_state == htts_pkg::S_SCAN);
        end
    end

    // counter memory
    assign mem_raddr = (r_state == htts_pkg::S_IDLE) ? in_addr : r_addr;
    assign mem_we    = (r_state == htts_pkg::S_CLEAR) || (r_state == htts_pkg::S_INC);
    assign mem_wdata = (r_state == htts_pkg::S_CLEAR) ? '0 :
                       (r_rd_data == COUNT_MAX) ? r_rd_data : r_rd_data + CW'(1);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
        r_rd_idx  <= r_addr;
    end

    assign rank_ctl.clear  = accept && (i_cmd == htts_pkg::CMD_SELECT);
    assign rank_ctl.insert = r_rd_vld;

    htts_rank #(
        .AW (AW),
        .CW (CW)
    ) u_rank (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (rank_ctl),
        .i_index      (r_rd_idx),
        .i_count      (r_rd_data),
        .o_slot_valid (slot_valid),
        .o_slot_index (slot_index),
        .o_slot_count (slot_count)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            for (int k = 0; k < htts_pkg::SLOTS; k++) begin
                if (slot_valid[k] && (slot_count[k] != '0)) begin
                    r_res_valid[k] <= 1'b1;
                    r_res_index[k] <= htts_pkg::IDX_W'(slot_index[k]);
                    r_res_count[k] <= htts_pkg::CNT_W'(slot_count[k]);
                end else begin
                    r_res_valid[k] <= 1'b0;
                    r_res_index[k] <= '0;
                    r_res_count[k] <= '0;
                end
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_first_index  = r_res_index[0];
    assign o_first_valid  = r_res_valid[0];
    assign o_first_count  = r_res_count[0];
    assign o_second_index = r_res_index[1];
    assign o_second_valid = r_res_valid[1];
    assign o_second_count = r_res_count[1];
    assign o_third_index  = r_res_index[2];
    assign o_third_valid  = r_res_valid[2];
    assign o_third_count  = r_res_count[2];

endmodule

// ----- rtl/htts_rank.sv -----
// ranked list of three entries with the shared insertion compare unit
`timescale 1ns / 1ps

module htts_rank #(
    parameter int AW = 6,
    parameter int CW = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  htts_pkg::t_rank_ctl             i_ctl,
    input  logic [AW-1:0]                   i_index,
    input  logic [CW-1:0]                   i_count,
    output logic [htts_pkg::SLOTS-1:0]      o_slot_valid,
    output logic [htts_pkg::SLOTS-1:0][AW-1:0] o_slot_index,
    output logic [htts_pkg::SLOTS-1:0][CW-1:0] o_slot_count
);

    logic [htts_pkg::SLOTS-1:0]         r_vld;
    logic [htts_pkg::SLOTS-1:0][AW-1:0] r_idx;
    logic [htts_pkg::SLOTS-1:0][CW-1:0] r_cnt;
    logic [htts_pkg::SLOTS-1:0]         take;

    always_comb begin
        for (int k = 0; k < htts_pkg::SLOTS; k++) begin
            take[k] = !r_vld[k] || (i_count >= r_cnt[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.clear) begin
            r_vld <= '0;
        end else if (i_ctl.insert) begin
            if (take[0]) begin
                r_vld <= {r_vld[1], r_vld[0], 1'b1};
            end else if (take[1]) begin
                r_vld <= {r_vld[1], 1'b1, r_vld[0]};
            end else if (take[2]) begin
                r_vld <= {1'b1, r_vld[1], r_vld[0]};
            end
        end
    end

    // insertion with push-down of the lower slots
    always_ff @(posedge i_clk) begin
        if (i_ctl.insert && !i_ctl.clear) begin
            if (take[0]) begin
                r_idx[2] <= r_idx[1];
                r_cnt[2] <= r_cnt[1];
                r_idx[1] <= r_idx[0];
                r_cnt[1] <= r_cnt[0];
                r_idx[0] <= i_index;
                r_cnt[0] <= i_count;
            end else if (take[1]) begin
                r_idx[2] <= r_idx[1];
                r_cnt[2] <= r_cnt[1];
                r_idx[1] <= i_index;
                r_cnt[1] <= i_count;
            end else if (take[2]) begin
                r_idx[2] <= i_index;
                r_cnt[2] <= i_count;
            end
        end
    end

    assign o_slot_valid = r_vld;
    assign o_slot_index = r_idx;
    assign o_slot_count = r_cnt;

endmodule
